// File: rtl/crse_pkg.sv
// Shared types and constants of the Catmull-Rom spline evaluator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package crse_pkg;

  localparam int MaxPoints = 256;
  localparam int IdxW      = 8;
  localparam int CntW      = 9;
  localparam int FracBits  = 16;
  localparam int TW        = 24;
  localparam int CoordW    = 32;
  localparam int PointW    = 3 * CoordW;
  localparam int WeightW   = 24;
  localparam int ProdW     = CoordW + WeightW;
  localparam int AccW      = ProdW + 2;

  localparam logic ActLoad = 1'b0;
  localparam logic ActEval = 1'b1;

  localparam logic [1:0] RegPointCount = 2'd0;
  localparam logic [1:0] RegLooped     = 2'd1;

  // One memory read of an evaluation, travelling down the datapath.
  typedef struct packed {
    logic                valid;
    logic                err;
    logic                last;
    logic [1:0]          k;
    logic [FracBits-1:0] f;
  } beat_t;

endpackage

// File: rtl/crse_ram.sv
// Control point memory: one port, registered synchronous read.
// Depends on crse_pkg.
`timescale 1ns / 1ps
module crse_ram
  import crse_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IdxW-1:0]   addr_i,
  input  logic [PointW-1:0] wdata_i,
  output logic [PointW-1:0] rdata_o
);

  logic [PointW-1:0] mem [MaxPoints];
  logic [PointW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/crse_seq.sv
// Front end: configuration registers, clamping of t, neighbor selection and
// the read sequencer that drives the point memory. Depends on crse_pkg.
`timescale 1ns / 1ps
module crse_seq
  import crse_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              action_i,
  input  logic [IdxW-1:0]   point_index_i,
  input  logic [TW-1:0]     t_value_i,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output logic              busy_o,
  output logic              ram_we_o,
  output logic [IdxW-1:0]   ram_addr_o,
  output beat_t             beat_o
);

  logic [CntW-1:0]     point_count_q;
  logic                looped_q;
  logic                active_q;
  logic [1:0]          cnt_q;
  logic [IdxW-1:0]     idx_q [3];
  logic [FracBits-1:0] f_q;

  logic [CntW-1:0]     n;
  logic                err;
  logic [TW:0]         tmax;
  logic [TW-1:0]       tc;
  logic [CntW-1:0]     seg;
  logic [CntW-1:0]     i0, i1, i2, i3;
  logic                accept, eval_go;

  assign accept  = start_i && !active_q;
  assign eval_go = accept && (action_i == ActEval);

  always_comb begin
    if (point_count_q == '0) begin
      n = CntW'(1);
    end else if (point_count_q > CntW'(MaxPoints)) begin
      n = CntW'(MaxPoints);
    end else begin
      n = point_count_q;
    end
    err  = !looped_q && (n < CntW'(4));
    tmax = looped_q ? {n[TW-FracBits:0], {FracBits{1'b0}}} - (TW+1)'(1)
                    : {n[TW-FracBits:0] - (TW-FracBits+1)'(3), {FracBits{1'b0}}} - (TW+1)'(1);
    tc   = ({1'b0, t_value_i} > tmax) ? tmax[TW-1:0] : t_value_i;
    seg  = {1'b0, tc[TW-1:FracBits]};
    if (looped_q) begin
      i1 = seg;
      i2 = (i1 + CntW'(1) >= n) ? '0 : i1 + CntW'(1);
      i3 = (i2 + CntW'(1) >= n) ? '0 : i2 + CntW'(1);
      i0 = (i1 >= CntW'(1)) ? i1 - CntW'(1) : n - CntW'(1);
    end else begin
      i0 = seg;
      i1 = seg + CntW'(1);
      i2 = seg + CntW'(2);
      i3 = seg + CntW'(3);
    end
  end

  function automatic logic [IdxW-1:0] clip(input logic [CntW-1:0] v);
    return (v >= CntW'(MaxPoints)) ? IdxW'(MaxPoints - 1) : v[IdxW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CntW'(4);
      looped_q      <= 1'b0;
      active_q      <= 1'b0;
      cnt_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == RegPointCount) begin
        point_count_q <= cfg_data_i[CntW-1:0];
      end else if (cfg_valid_i && cfg_index_i == RegLooped) begin
        looped_q <= cfg_data_i[0];
      end
      if (active_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          active_q <= 1'b0;
        end
      end else if (eval_go && !err) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      idx_q[0] <= clip(i1);
      idx_q[1] <= clip(i2);
      idx_q[2] <= clip(i3);
      f_q      <= tc[FracBits-1:0];
    end
  end

  always_comb begin
    beat_o = '0;
    if (active_q) begin
      ram_addr_o   = idx_q[cnt_q];
      beat_o.valid = 1'b1;
      beat_o.k     = cnt_q + 2'd1;
      beat_o.last  = (cnt_q == 2'd2);
      beat_o.f     = f_q;
    end else if (accept && action_i == ActLoad) begin
      ram_addr_o = point_index_i;
    end else begin
      ram_addr_o   = clip(i0);
      beat_o.valid = eval_go;
      beat_o.err   = err;
      beat_o.last  = err;
      beat_o.f     = tc[FracBits-1:0];
    end
  end

  assign ram_we_o = accept && (action_i == ActLoad);
  assign busy_o   = active_q;

endmodule

// File: rtl/crse_dp.sv
// Arithmetic pipeline: fraction powers, weights, products, accumulation,
// rounding and saturation of each result. Depends on crse_pkg.
`timescale 1ns / 1ps
module crse_dp
  import crse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  beat_t                    beat_i,
  input  logic [PointW-1:0]        rdata_i,
  output logic                     out_valid_o,
  output logic signed [CoordW-1:0] res_o [6],
  output logic                     status_o
);

  beat_t b1_q, b2_q, b3_q, b4_q, b5_q, b6_q;
  logic [PointW-1:0]         d2_q, d3_q, d4_q;
  logic [FracBits-1:0]       f2_2_q, f2_3_q, f3_3_q;
  logic [2*FracBits-1:0]     sq, cube;
  logic signed [WeightW-1:0] wp_q, wg_q, wp, wg;
  logic signed [WeightW-1:0] sf, sf2, sf3;
  logic signed [ProdW-1:0]   prod_q [6];
  logic signed [AccW-1:0]    acc_q  [6];
  logic signed [CoordW-1:0]  res_q  [6];
  logic                      out_valid_q, status_q;

  localparam logic signed [WeightW-1:0] One = WeightW'(1 << FracBits);
  localparam logic signed [AccW-1:0]    SatHi = AccW'(32'sh7FFFFFFF);
  localparam logic signed [AccW-1:0]    SatLo = AccW'(32'sh80000000);

  function automatic logic signed [CoordW-1:0] finish(input logic signed [AccW-1:0] s);
    logic signed [AccW-1:0] r;
    r = (s + AccW'(1 << FracBits)) >>> (FracBits + 1);
    if (r > SatHi) begin
      return 32'sh7FFFFFFF;
    end else if (r < SatLo) begin
      return 32'sh80000000;
    end
    return r[CoordW-1:0];
  endfunction

  assign sq   = b1_q.f * b1_q.f;
  assign cube = f2_2_q * b2_q.f;
  assign sf   = WeightW'(b3_q.f);
  assign sf2  = WeightW'(f2_3_q);
  assign sf3  = WeightW'(f3_3_q);

  always_comb begin
    unique case (b3_q.k)
      2'd0: begin
        wp = WeightW'(-sf3 + 2 * sf2 - sf);
        wg = WeightW'(-3 * sf2 + 4 * sf - One);
      end
      2'd1: begin
        wp = WeightW'(3 * sf3 - 5 * sf2 + 2 * One);
        wg = WeightW'(9 * sf2 - 10 * sf);
      end
      2'd2: begin
        wp = WeightW'(-3 * sf3 + 4 * sf2 + sf);
        wg = WeightW'(-9 * sf2 + 8 * sf + One);
      end
      default: begin
        wp = sf3 - sf2;
        wg = WeightW'(3 * sf2 - 2 * sf);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q        <= '0;
      b2_q        <= '0;
      b3_q        <= '0;
      b4_q        <= '0;
      b5_q        <= '0;
      b6_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      b1_q        <= beat_i;
      b2_q        <= b1_q;
      b3_q        <= b2_q;
      b4_q        <= b3_q;
      b5_q        <= b4_q;
      b6_q        <= b5_q;
      out_valid_q <= b6_q.valid && b6_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q   <= rdata_i;
    f2_2_q <= sq[2*FracBits-1:FracBits];
    d3_q   <= d2_q;
    f2_3_q <= f2_2_q;
    f3_3_q <= cube[2*FracBits-1:FracBits];
    d4_q   <= d3_q;
    wp_q   <= wp;
    wg_q   <= wg;
    for (int c = 0; c < 3; c++) begin
      prod_q[c]     <= signed'(d4_q[c*CoordW +: CoordW]) * wp_q;
      prod_q[3 + c] <= signed'(d4_q[c*CoordW +: CoordW]) * wg_q;
    end
    if (b5_q.valid) begin
      for (int j = 0; j < 6; j++) begin
        acc_q[j] <= ((b5_q.k == 2'd0) ? AccW'(0) : acc_q[j]) + AccW'(prod_q[j]);
      end
    end
    if (b6_q.valid && b6_q.last) begin
      status_q <= b6_q.err;
      for (int j = 0; j < 6; j++) begin
        res_q[j] <= b6_q.err ? '0 : finish(acc_q[j]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign status_o    = status_q;

endmodule

// File: rtl/catmull_rom_spline_eval.sv
// Catmull-Rom spline evaluator for 3D control points in Q16.16.
// Load items are taken every cycle while busy_o is low and write the point memory at acceptance.
// An evaluate item without error holds busy_o while the other three neighbors are read, so no new
// item is taken before all four points are read by the single memory port reading one point per cycle.
// Reset clears control and config (point_count 4, open spline), not the point memory.
`timescale 1ns / 1ps
module catmull_rom_spline_eval
  import crse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     action_i,
  input  logic [IdxW-1:0]          point_index_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  input  logic [TW-1:0]            t_value_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [15:0]              cfg_data_i,
  output logic                     out_valid_o,
  output logic signed [CoordW-1:0] pos_x_o,
  output logic signed [CoordW-1:0] pos_y_o,
  output logic signed [CoordW-1:0] pos_z_o,
  output logic signed [CoordW-1:0] grad_x_o,
  output logic signed [CoordW-1:0] grad_y_o,
  output logic signed [CoordW-1:0] grad_z_o,
  output logic                     status_o
);

  logic                     ram_we;
  logic [IdxW-1:0]          ram_addr;
  logic [PointW-1:0]        ram_rdata;
  beat_t                    beat;
  logic signed [CoordW-1:0] res [6];

  // Configuration beats are always taken; writes must only happen while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  // The sequencer reads the first neighbor in the acceptance cycle and the
  // other three in the following cycles (not on a too-few-points error); each read travels as one beat.
  crse_seq u_seq (
    .clk_i,
    .rst_ni,
    .start_i,
    .action_i,
    .point_index_i,
    .t_value_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .busy_o,
    .ram_we_o   (ram_we),
    .ram_addr_o (ram_addr),
    .beat_o     (beat)
  );

  // Points are packed with x in the low word and z in the high word.
  crse_ram u_ram (
    .clk_i,
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({coord_z_i, coord_y_i, coord_x_i}),
    .rdata_o (ram_rdata)
  );

  // Beats of one evaluation are contiguous, so the accumulators restart on
  // the first beat and the result is taken on the last.
  crse_dp u_dp (
    .clk_i,
    .rst_ni,
    .beat_i      (beat),
    .rdata_i     (ram_rdata),
    .out_valid_o,
    .res_o       (res),
    .status_o
  );

  assign pos_x_o  = res[0];
  assign pos_y_o  = res[1];
  assign pos_z_o  = res[2];
  assign grad_x_o = res[3];
  assign grad_y_o = res[4];
  assign grad_z_o = res[5];

endmodule
